/* hdl/spd_pkg.sv */
package spd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 8;
    localparam int CFG_W    = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_HIGH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOW     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PACKAGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MID_LEVEL         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ARM_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HOLD_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ARM_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HOLD_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RELEASE_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PEAKS_PER_PACKAGE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD_COUNT    = 3'd7;

    localparam logic [CFG_W-1:0] RST_MID_LEVEL         = 8'd127;
    localparam logic [CFG_W-1:0] RST_HIGH_ARM_LEVEL    = 8'd220;
    localparam logic [CFG_W-1:0] RST_HIGH_HOLD_LEVEL   = 8'd170;
    localparam logic [CFG_W-1:0] RST_LOW_ARM_LEVEL     = 8'd40;
    localparam logic [CFG_W-1:0] RST_LOW_HOLD_LEVEL    = 8'd85;
    localparam logic [CFG_W-1:0] RST_LOW_RELEASE_LEVEL = 8'd88;
    localparam logic [CFG_W-1:0] RST_PEAKS_PER_PACKAGE = 8'd32;
    localparam logic [CFG_W-1:0] RST_MIN_HOLD_COUNT    = 8'd2;

    localparam logic [SAMPLE_W-1:0] TRACK_RESET = 8'd127;
    localparam logic [7:0]          COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [CFG_W-1:0] mid_level;
        logic [CFG_W-1:0] high_arm_level;
        logic [CFG_W-1:0] high_hold_level;
        logic [CFG_W-1:0] low_arm_level;
        logic [CFG_W-1:0] low_hold_level;
        logic [CFG_W-1:0] low_release_level;
        logic [CFG_W-1:0] peaks_per_package;
        logic [CFG_W-1:0] min_hold_count;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] peak_value;
        logic [POS_W-1:0]    peak_position;
        logic                source_buffer;
    } t_result;

endpackage

/* hdl/sample_peak_detector.sv */
// Sample peak detector with hysteresis.
// Input stream: one sample per beat. s_tdata holds sample and position,
// s_tuser the buffer id (A = 0, B = 1). Thresholds are loaded through the
// write port (i_cfg_we / i_cfg_index / i_cfg_data); the user must load them
// only while the stream is idle; the block does not enforce it. Output
// stream: zero or one result per input beat. m_tdata holds the peak value
// and position, m_tuser the kind (high, low, package ready) and the source
// buffer. Throughput: one beat per cycle while o_s_tready is high; the
// compare-and-update of the trackers is a single combinational step between
// input handshake and output register, or the skid register while the output
// register is held. Output side is a two-entry queue (output register plus
// skid register); when the receiver stalls and both are full, o_s_tready
// drops until the receiver takes a beat, then rises again the next cycle.
// Reset (synchronous, active low): registers return to their defaults,
// trackers restart at midscale, counters clear and the queue empties.
module sample_peak_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] sample, [15:8] position
    input  logic        i_s_tuser,   // [0] buffer_id
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] peak_value, [15:8] peak_position
    output logic [2:0]  o_m_tuser,   // [1:0] kind, [2] source_buffer
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    spd_pkg::t_cfg    r_cfg;
    spd_pkg::t_result w_res;
    spd_pkg::t_result r_out, n_out;
    spd_pkg::t_result r_skid, n_skid;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mid_level         <= spd_pkg::RST_MID_LEVEL;
            r_cfg.high_arm_level    <= spd_pkg::RST_HIGH_ARM_LEVEL;
            r_cfg.high_hold_level   <= spd_pkg::RST_HIGH_HOLD_LEVEL;
            r_cfg.low_arm_level     <= spd_pkg::RST_LOW_ARM_LEVEL;
            r_cfg.low_hold_level    <= spd_pkg::RST_LOW_HOLD_LEVEL;
            r_cfg.low_release_level <= spd_pkg::RST_LOW_RELEASE_LEVEL;
            r_cfg.peaks_per_package <= spd_pkg::RST_PEAKS_PER_PACKAGE;
            r_cfg.min_hold_count    <= spd_pkg::RST_MIN_HOLD_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spd_pkg::REG_MID_LEVEL:         r_cfg.mid_level         <= i_cfg_data;
                spd_pkg::REG_HIGH_ARM_LEVEL:    r_cfg.high_arm_level    <= i_cfg_data;
                spd_pkg::REG_HIGH_HOLD_LEVEL:   r_cfg.high_hold_level   <= i_cfg_data;
                spd_pkg::REG_LOW_ARM_LEVEL:     r_cfg.low_arm_level     <= i_cfg_data;
                spd_pkg::REG_LOW_HOLD_LEVEL:    r_cfg.low_hold_level    <= i_cfg_data;
                spd_pkg::REG_LOW_RELEASE_LEVEL: r_cfg.low_release_level <= i_cfg_data;
                spd_pkg::REG_PEAKS_PER_PACKAGE: r_cfg.peaks_per_package <= i_cfg_data;
                spd_pkg::REG_MIN_HOLD_COUNT:    r_cfg.min_hold_count    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    spd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_sample    (i_s_tdata[7:0]),
        .i_position  (i_s_tdata[15:8]),
        .i_buffer_id (i_s_tuser),
        .i_cfg       (r_cfg),
        .o_result    (w_res)
    );

    assign w_push = w_accept && w_res.valid;
    assign w_pop  = r_out_valid && i_m_tready;

    // skid only fills when the output register is held, and drains into it
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.peak_position, r_out.peak_value};
    assign o_m_tuser  = {r_out.source_buffer, r_out.kind};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held with empty output register");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("result beat lost");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_tready) |=> (r_skid_valid && $stable(r_out)))
        else $error("queued beats changed during stall");

endmodule

/* hdl/spd_core.sv */
module spd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [spd_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [spd_pkg::POS_W-1:0]     i_position,
    input  logic                          i_buffer_id,
    input  spd_pkg::t_cfg                 i_cfg,
    output spd_pkg::t_result              o_result
);

    logic [spd_pkg::SAMPLE_W-1:0] r_high_value, n_high_value;
    logic [spd_pkg::POS_W-1:0]    r_high_place, n_high_place;
    logic [spd_pkg::SAMPLE_W-1:0] r_low_value,  n_low_value;
    logic [spd_pkg::POS_W-1:0]    r_low_place,  n_low_place;
    logic                         r_high_armed, n_high_armed;
    logic                         r_low_armed,  n_low_armed;
    logic [7:0]                   r_hold_count, n_hold_count;
    logic [7:0]                   r_peaks [2];
    logic [7:0]                   n_peaks [2];
    logic [7:0]                   w_hold_inc;
    logic [7:0]                   w_peak_inc;
    spd_pkg::t_result             w_res;

    assign w_hold_inc = (r_hold_count == spd_pkg::COUNT_MAX) ? r_hold_count
                                                             : r_hold_count + 8'd1;
    assign w_peak_inc = (r_peaks[i_buffer_id] == spd_pkg::COUNT_MAX)
                        ? r_peaks[i_buffer_id] : r_peaks[i_buffer_id] + 8'd1;

    always_comb begin
        n_high_value = r_high_value;
        n_high_place = r_high_place;
        n_low_value  = r_low_value;
        n_low_place  = r_low_place;
        n_high_armed = r_high_armed;
        n_low_armed  = r_low_armed;
        n_hold_count = r_hold_count;
        n_peaks[0]   = r_peaks[0];
        n_peaks[1]   = r_peaks[1];
        w_res        = '0;
        w_res.source_buffer = i_buffer_id;

        if (r_peaks[i_buffer_id] >= i_cfg.peaks_per_package) begin
            n_peaks[i_buffer_id] = 8'd0;
            w_res.valid = 1'b1;
            w_res.kind  = spd_pkg::KIND_PACKAGE;
        end else if (i_sample > i_cfg.mid_level) begin
            if (i_sample > r_high_value) begin
                if (i_sample > i_cfg.high_arm_level) begin
                    n_high_value = i_sample;
                    n_high_place = i_position;
                    n_high_armed = 1'b1;
                    n_low_armed  = 1'b0;
                end
            end else if (i_sample > i_cfg.high_hold_level) begin
                n_hold_count = w_hold_inc;
            end else if (i_sample < i_cfg.high_hold_level) begin
                if (r_high_armed && (r_hold_count > i_cfg.min_hold_count)) begin
                    w_res.valid         = 1'b1;
                    w_res.kind          = spd_pkg::KIND_HIGH;
                    w_res.peak_value    = r_high_value;
                    w_res.peak_position = r_high_place;
                    n_peaks[i_buffer_id] = w_peak_inc;
                    n_high_value = i_cfg.mid_level;
                    n_high_armed = 1'b0;
                    n_hold_count = 8'd0;
                end
            end
        end else begin
            if (i_sample < r_low_value) begin
                if (i_sample < i_cfg.low_arm_level) begin
                    n_low_value  = i_sample;
                    n_low_place  = i_position;
                    n_low_armed  = 1'b1;
                    n_high_armed = 1'b0;
                end
            end else if (i_sample < i_cfg.low_hold_level) begin
                n_hold_count = w_hold_inc;
            end else if (i_sample > i_cfg.low_release_level) begin
                if (r_low_armed && (r_hold_count > i_cfg.min_hold_count)) begin
                    w_res.valid         = 1'b1;
                    w_res.kind          = spd_pkg::KIND_LOW;
                    w_res.peak_value    = r_low_value;
                    w_res.peak_position = r_low_place;
                    n_peaks[i_buffer_id] = w_peak_inc;
                    n_low_value  = i_cfg.mid_level;
                    n_low_armed  = 1'b0;
                    n_hold_count = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_value <= spd_pkg::TRACK_RESET;
            r_high_place <= '0;
            r_low_value  <= spd_pkg::TRACK_RESET;
            r_low_place  <= '0;
            r_high_armed <= 1'b0;
            r_low_armed  <= 1'b0;
            r_hold_count <= 8'd0;
            r_peaks[0]   <= 8'd0;
            r_peaks[1]   <= 8'd0;
        end else if (i_accept) begin
            r_high_value <= n_high_value;
            r_high_place <= n_high_place;
            r_low_value  <= n_low_value;
            r_low_place  <= n_low_place;
            r_high_armed <= n_high_armed;
            r_low_armed  <= n_low_armed;
            r_hold_count <= n_hold_count;
            r_peaks[0]   <= n_peaks[0];
            r_peaks[1]   <= n_peaks[1];
        end
    end

    assign o_result = w_res;

    a_arm_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_high_armed && r_low_armed))
        else $error("both trackers armed");

    a_hold_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.valid && (w_res.kind != spd_pkg::KIND_PACKAGE))
        |=> (r_hold_count == 8'd0))
        else $error("hold count not cleared after peak");

    a_pkg_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.valid && (w_res.kind == spd_pkg::KIND_PACKAGE))
        |=> (r_peaks[$past(i_buffer_id)] == 8'd0))
        else $error("peak counter not cleared after package ready");

endmodule

/* tb/sv/sample_peak_detector_tb.sv */
`timescale 1ns / 1ps

module sample_peak_detector_tb;

    typedef struct packed {
        logic [spd_pkg::SAMPLE_W-1:0] sample;
        logic [spd_pkg::POS_W-1:0]    position;
        logic                         src;
    } t_sample_beat;

    typedef struct packed {
        logic [spd_pkg::KIND_W-1:0]   kind;
        logic [spd_pkg::SAMPLE_W-1:0] value;
        logic [spd_pkg::POS_W-1:0]    place;
        logic                         src;
    } t_peak_beat;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [15:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tready   = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_idx    = '0;
    logic [7:0]  cfg_dat    = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;   // [7:0] peak_value, [15:8] peak_position
    wire  [2:0]  o_m_tuser;   // [1:0] kind, [2] source_buffer

    sample_peak_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),    // [7:0] sample, [15:8] position
        .i_s_tuser   (s_tuser),    // [0] buffer_id
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat)
    );

    // predictor state and register shadow
    spd_pkg::t_cfg                cfg_now;
    spd_pkg::t_cfg                cfg_next;
    logic [spd_pkg::SAMPLE_W-1:0] hi_val   = spd_pkg::TRACK_RESET;
    logic [spd_pkg::POS_W-1:0]    hi_at    = '0;
    logic [spd_pkg::SAMPLE_W-1:0] lo_val   = spd_pkg::TRACK_RESET;
    logic [spd_pkg::POS_W-1:0]    lo_at    = '0;
    logic                         hi_armed = 1'b0;
    logic                         lo_armed = 1'b0;
    logic [7:0]                   hold_cnt = '0;
    logic [7:0]                   pkg_count [2];

    t_sample_beat samples_pending [$];
    t_peak_beat   peaks_due [$];
    t_sample_beat cur      = '0;
    t_peak_beat   due;
    t_peak_beat   want;
    bit           got;
    bit           offering = 1'b0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           calm     = 1'b0;
    bit           hold_go  = 1'b0;
    logic         hold_off = 1'b0;

    int n_in = 0, n_high = 0, n_low = 0, n_pkg = 0, n_bad = 0, n_settings = 0;

    initial begin
        pkg_count[0] = '0;
        pkg_count[1] = '0;
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic spd_pkg::t_cfg make_cfg(input int mid, input int ha, input int hh,
                                               input int la, input int lh, input int lr,
                                               input int ppp, input int mh);
        spd_pkg::t_cfg c;
        c.mid_level         = 8'(mid);
        c.high_arm_level    = 8'(ha);
        c.high_hold_level   = 8'(hh);
        c.low_arm_level     = 8'(la);
        c.low_hold_level    = 8'(lh);
        c.low_release_level = 8'(lr);
        c.peaks_per_package = 8'(ppp);
        c.min_hold_count    = 8'(mh);
        return c;
    endfunction

    function automatic spd_pkg::t_cfg rand_cfg(input bit wild);
        int mid, hh, lh;
        if (wild) begin
            return make_cfg($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 254));
        end
        mid = $urandom_range(64, 192);
        hh  = $urandom_range(mid + 1, 240);
        lh  = $urandom_range(16, mid);
        return make_cfg(mid, $urandom_range(hh, 250), hh, $urandom_range(5, lh), lh,
                        $urandom_range(lh, mid), $urandom_range(1, 12), $urandom_range(0, 6));
    endfunction

    function automatic int clip8(input int x);
        return (x < 0) ? 0 : (x > 255) ? 255 : x;
    endfunction

    function automatic int idle_draw();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic void bump_hold();
        if (hold_cnt < spd_pkg::COUNT_MAX)
            hold_cnt++;
    endfunction

    function automatic void bump_pkg(input logic src);
        if (pkg_count[src] < spd_pkg::COUNT_MAX)
            pkg_count[src]++;
    endfunction

    function automatic bit detect_peak(input t_sample_beat it, output t_peak_beat r);
        r = '0;
        r.src = it.src;
        if (pkg_count[it.src] >= cfg_now.peaks_per_package) begin
            pkg_count[it.src] = '0;
            r.kind = spd_pkg::KIND_PACKAGE;
            return 1'b1;
        end
        if (it.sample > cfg_now.mid_level) begin
            if (it.sample > hi_val) begin
                if (it.sample > cfg_now.high_arm_level) begin
                    hi_val   = it.sample;
                    hi_at    = it.position;
                    hi_armed = 1'b1;
                    lo_armed = 1'b0;
                end
            end else if (it.sample > cfg_now.high_hold_level) begin
                bump_hold();
            end else if (it.sample < cfg_now.high_hold_level) begin
                if (hi_armed && hold_cnt > cfg_now.min_hold_count) begin
                    r.kind   = spd_pkg::KIND_HIGH;
                    r.value  = hi_val;
                    r.place  = hi_at;
                    bump_pkg(it.src);
                    hi_val   = cfg_now.mid_level;
                    hi_armed = 1'b0;
                    hold_cnt = '0;
                    return 1'b1;
                end
            end
        end else begin
            if (it.sample < lo_val) begin
                if (it.sample < cfg_now.low_arm_level) begin
                    lo_val   = it.sample;
                    lo_at    = it.position;
                    lo_armed = 1'b1;
                    hi_armed = 1'b0;
                end
            end else if (it.sample < cfg_now.low_hold_level) begin
                bump_hold();
            end else if (it.sample > cfg_now.low_release_level) begin
                if (lo_armed && hold_cnt > cfg_now.min_hold_count) begin
                    r.kind   = spd_pkg::KIND_LOW;
                    r.value  = lo_val;
                    r.place  = lo_at;
                    bump_pkg(it.src);
                    lo_val   = cfg_now.mid_level;
                    lo_armed = 1'b0;
                    hold_cnt = '0;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic queue_at(input int s, input int pos, input bit src);
        t_sample_beat b;
        b.sample   = 8'(s);
        b.position = 8'(pos);
        b.src      = src;
        samples_pending.push_back(b);
    endtask

    task automatic queue_sample(input int s);
        queue_at(s, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endtask

    // one well-formed peak: arm, a run of hold beats, then release
    task automatic queue_burst();
        int mid, ha, hh, la, lh, lr, pk, n;
        mid = cfg_now.mid_level;
        ha  = cfg_now.high_arm_level;
        hh  = cfg_now.high_hold_level;
        la  = cfg_now.low_arm_level;
        lh  = cfg_now.low_hold_level;
        lr  = cfg_now.low_release_level;
        if (cfg_now.min_hold_count < 8)
            n = $urandom_range(0, cfg_now.min_hold_count + 3);
        else if ($urandom_range(0, 15) == 0)
            n = $urandom_range(200, 300);
        else
            n = $urandom_range(0, 20);
        if ($urandom_range(0, 1)) begin
            pk = $urandom_range(clip8(ha + 1), 255);
            queue_sample(pk);
            repeat (n) queue_sample($urandom_range(clip8(hh + 1), pk));
            queue_sample($urandom_range(clip8(mid + 1), clip8(hh - 1)));
        end else begin
            pk = $urandom_range(0, clip8(la - 1));
            queue_sample(pk);
            repeat (n) queue_sample($urandom_range(pk, clip8(lh - 1)));
            queue_sample($urandom_range(clip8(lr + 1), mid));
        end
    endtask

    task automatic queue_random(input int n);
        int target;
        @(negedge i_clk);
        target = samples_pending.size() + n;
        while (samples_pending.size() < target) begin
            if ($urandom_range(0, 3) != 0)
                queue_burst();
            else
                repeat ($urandom_range(1, 3)) queue_sample($urandom_range(0, 255));
        end
    endtask

    task automatic load_cfg(input spd_pkg::t_cfg c);
        @(posedge i_clk);
        cfg_we  <= 1'b1;
        cfg_idx <= spd_pkg::REG_MID_LEVEL;
        cfg_dat <= c.mid_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_HIGH_ARM_LEVEL;
        cfg_dat <= c.high_arm_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_HIGH_HOLD_LEVEL;
        cfg_dat <= c.high_hold_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_LOW_ARM_LEVEL;
        cfg_dat <= c.low_arm_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_LOW_HOLD_LEVEL;
        cfg_dat <= c.low_hold_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_LOW_RELEASE_LEVEL;
        cfg_dat <= c.low_release_level;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_PEAKS_PER_PACKAGE;
        cfg_dat <= c.peaks_per_package;
        @(posedge i_clk);
        cfg_idx <= spd_pkg::REG_MIN_HOLD_COUNT;
        cfg_dat <= c.min_hold_count;
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        cfg_now = c;
        n_settings++;
    endtask

    // all beats sent and answered, then a settling wait for the output register
    task automatic wait_idle();
        while (samples_pending.size() != 0 || offering || peaks_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                got = detect_peak(cur, due);
                if (got)
                    peaks_due.push_back(due);
                n_in++;
                offering = 1'b0;
                gap_left = idle_draw();
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (samples_pending.size() != 0) begin
                    cur = samples_pending.pop_front();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tdata  <= {cur.position, cur.sample};
            s_tuser  <= cur.src;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                case (o_m_tuser[1:0])
                    spd_pkg::KIND_HIGH:    n_high++;
                    spd_pkg::KIND_LOW:     n_low++;
                    spd_pkg::KIND_PACKAGE: n_pkg++;
                    default: ;
                endcase
                if (peaks_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected beat: kind %0d value %0d position %0d buffer %0d",
                                 o_m_tuser[1:0], o_m_tdata[7:0], o_m_tdata[15:8], o_m_tuser[2]);
                end else begin
                    want = peaks_due.pop_front();
                    if (o_m_tuser[1:0] !== want.kind || o_m_tdata[7:0] !== want.value ||
                        o_m_tdata[15:8] !== want.place || o_m_tuser[2] !== want.src) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("exp kind %0d value %0d pos %0d buf %0d, got %0d %0d %0d %0d",
                                     want.kind, want.value, want.place, want.src,
                                     o_m_tuser[1:0], o_m_tdata[7:0], o_m_tdata[15:8],
                                     o_m_tuser[2]);
                    end
                end
                stall_left = idle_draw();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= !hold_off && stall_left == 0;
        end
    end

    // long receiver hold-off so the output queue fills and input backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("sample_peak_detector: mismatch");
        $finish;
    end

    initial begin
        cfg_now = make_cfg(spd_pkg::RST_MID_LEVEL, spd_pkg::RST_HIGH_ARM_LEVEL,
                           spd_pkg::RST_HIGH_HOLD_LEVEL, spd_pkg::RST_LOW_ARM_LEVEL,
                           spd_pkg::RST_LOW_HOLD_LEVEL, spd_pkg::RST_LOW_RELEASE_LEVEL,
                           spd_pkg::RST_PEAKS_PER_PACKAGE, spd_pkg::RST_MIN_HOLD_COUNT);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset levels
        queue_at(255, 255, 1);   // arm high at full scale
        queue_at(170, 3, 0);     // equal to hold level: no effect
        queue_at(200, 4, 0);
        queue_at(221, 5, 1);
        queue_at(171, 6, 0);
        queue_at(169, 7, 1);     // release high
        queue_at(169, 8, 0);     // above tracker, below arm: no effect
        queue_at(0, 0, 0);       // arm low at zero
        queue_at(85, 9, 1);      // inside low dead band
        queue_at(88, 10, 0);
        queue_at(50, 11, 0);
        queue_at(100, 12, 1);    // release with too few holds
        queue_at(84, 13, 0);
        queue_at(1, 14, 1);
        queue_at(127, 15, 0);    // release low
        queue_at(230, 16, 1);
        queue_at(128, 17, 0);    // no release straight after arming
        wait_idle();

        // all zero: every beat is package ready; long output stall here
        calm = 1'b1;
        load_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
        hold_go = 1'b1;
        queue_random(80);
        wait_idle();

        calm = 1'b0;
        load_cfg(make_cfg(255, 255, 255, 255, 255, 255, 255, 254));
        queue_random(80);
        wait_idle();

        cfg_next = rand_cfg(1'b0);
        cfg_next.peaks_per_package = 8'd1;
        cfg_next.min_hold_count    = 8'd0;
        load_cfg(cfg_next);
        queue_random(100);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            calm = (p % 3 == 2);
            load_cfg(rand_cfg(p % 4 == 3));
            queue_random(120);
            wait_idle();
        end

        $display("%0d samples over %0d register settings, %0d mismatches",
                 n_in, n_settings, n_bad);
        $display("results: %0d high peaks, %0d low peaks, %0d package-ready",
                 n_high, n_low, n_pkg);
        if (n_bad == 0)
            $display("sample_peak_detector: match");
        else
            $display("sample_peak_detector: mismatch");
        $finish;
    end

endmodule

/* files.f */
hdl/spd_pkg.sv
hdl/spd_core.sv
hdl/sample_peak_detector.sv
tb/sv/sample_peak_detector_tb.sv
